[hw/rtl/fnb_pkg.sv]
// Shared types, constants, F-number table and small arithmetic helpers
// for the note to F-number block. No dependencies.
package fnb_pkg;

    typedef struct packed {
        logic [3:0]        voice_index;
        logic              key_on;
        logic [6:0]        note_number;
        logic signed [7:0] transpose;
        logic [13:0]       pitch_bend;
    } in_item_t;

    typedef struct packed {
        logic [3:0] voice_out;
        logic       low_valid;
        logic [7:0] fnum_low;
        logic [7:0] key_block_high;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic       key_on;
        logic [3:0] voice;
    } stage_ctl_t;

    localparam logic [13:0]        BEND_CENTER      = 14'h2000;
    localparam logic [4:0]         BEND_RANGE_RESET = 5'd12;
    localparam logic [7:0]         KEY_OFF_MASK     = 8'hDF;
    localparam logic [7:0]         KEY_BIT          = 8'h20;
    localparam logic signed [11:0] POS_MAX          = 12'sd1535;
    localparam logic signed [11:0] POS_TOP_BASE     = 12'sd1344;
    localparam logic signed [11:0] POS_NEG_BIAS     = 12'sd576;
    localparam logic signed [8:0]  SEMI_OFFSET      = 9'sd12;
    localparam logic signed [8:0]  SEMI_MAX         = 9'sd95;
    localparam logic signed [8:0]  SEMI_TOP_BASE    = 9'sd84;
    localparam logic signed [8:0]  SEMI_NEG_BIAS    = 9'sd144;
    localparam logic [15:0]        DIV12_RECIP      = 16'd171;

    localparam logic [15:0] FNUM_TABLE [192] = '{
        16'h02b2, 16'h02b4, 16'h02b7, 16'h02b9, 16'h02bc, 16'h02be, 16'h02c1, 16'h02c3,
        16'h02c6, 16'h02c9, 16'h02cb, 16'h02ce, 16'h02d0, 16'h02d3, 16'h02d6, 16'h02d8,
        16'h02db, 16'h02dd, 16'h02e0, 16'h02e3, 16'h02e5, 16'h02e8, 16'h02eb, 16'h02ed,
        16'h02f0, 16'h02f3, 16'h02f6, 16'h02f8, 16'h02fb, 16'h02fe, 16'h0301, 16'h0303,
        16'h0306, 16'h0309, 16'h030c, 16'h030f, 16'h0311, 16'h0314, 16'h0317, 16'h031a,
        16'h031d, 16'h0320, 16'h0323, 16'h0326, 16'h0329, 16'h032b, 16'h032e, 16'h0331,
        16'h0334, 16'h0337, 16'h033a, 16'h033d, 16'h0340, 16'h0343, 16'h0346, 16'h0349,
        16'h034c, 16'h034f, 16'h0352, 16'h0356, 16'h0359, 16'h035c, 16'h035f, 16'h0362,
        16'h0365, 16'h0368, 16'h036b, 16'h036f, 16'h0372, 16'h0375, 16'h0378, 16'h037b,
        16'h037f, 16'h0382, 16'h0385, 16'h0388, 16'h038c, 16'h038f, 16'h0392, 16'h0395,
        16'h0399, 16'h039c, 16'h039f, 16'h03a3, 16'h03a6, 16'h03a9, 16'h03ad, 16'h03b0,
        16'h03b4, 16'h03b7, 16'h03bb, 16'h03be, 16'h03c1, 16'h03c5, 16'h03c8, 16'h03cc,
        16'h03cf, 16'h03d3, 16'h03d7, 16'h03da, 16'h03de, 16'h03e1, 16'h03e5, 16'h03e8,
        16'h03ec, 16'h03f0, 16'h03f3, 16'h03f7, 16'h03fb, 16'h03fe, 16'hfe01, 16'hfe03,
        16'hfe05, 16'hfe07, 16'hfe08, 16'hfe0a, 16'hfe0c, 16'hfe0e, 16'hfe10, 16'hfe12,
        16'hfe14, 16'hfe16, 16'hfe18, 16'hfe1a, 16'hfe1c, 16'hfe1e, 16'hfe20, 16'hfe21,
        16'hfe23, 16'hfe25, 16'hfe27, 16'hfe29, 16'hfe2b, 16'hfe2d, 16'hfe2f, 16'hfe31,
        16'hfe34, 16'hfe36, 16'hfe38, 16'hfe3a, 16'hfe3c, 16'hfe3e, 16'hfe40, 16'hfe42,
        16'hfe44, 16'hfe46, 16'hfe48, 16'hfe4a, 16'hfe4c, 16'hfe4f, 16'hfe51, 16'hfe53,
        16'hfe55, 16'hfe57, 16'hfe59, 16'hfe5c, 16'hfe5e, 16'hfe60, 16'hfe62, 16'hfe64,
        16'hfe67, 16'hfe69, 16'hfe6b, 16'hfe6d, 16'hfe6f, 16'hfe72, 16'hfe74, 16'hfe76,
        16'hfe79, 16'hfe7b, 16'hfe7d, 16'hfe7f, 16'hfe82, 16'hfe84, 16'hfe86, 16'hfe89,
        16'hfe8b, 16'hfe8d, 16'hfe90, 16'hfe92, 16'hfe95, 16'hfe97, 16'hfe99, 16'hfe9c,
        16'hfe9e, 16'hfea1, 16'hfea3, 16'hfea5, 16'hfea8, 16'hfeaa, 16'hfead, 16'hfeaf
    };

    // floor(x / 12) for x below 256, by reciprocal multiply
    function automatic logic [4:0] div12(input logic [7:0] x);
        logic [15:0] prod;
        prod = {8'b0, x} * DIV12_RECIP;
        return prod[15:11];
    endfunction

    function automatic logic [3:0] mod12(input logic [7:0] x);
        logic [4:0] q;
        logic [7:0] r;
        q = div12(x);
        r = x - ({q, 3'b000} + {1'b0, q, 2'b00});
        return r[3:0];
    endfunction

    // x mod 192 for x below 768
    function automatic logic [7:0] mod192(input logic [9:0] x);
        logic [1:0] m3;
        case (x[9:6])
            4'd0, 4'd3, 4'd6, 4'd9:  m3 = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10: m3 = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd11: m3 = 2'd2;
            default:                 m3 = 2'd0;
        endcase
        return {m3, x[5:0]};
    endfunction

endpackage

[hw/rtl/fnb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fnb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 9,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fnb_pitch_pipe.sv]
// Three-stage pitch pipeline: bend term, octave fold of the note, and
// 1/16-semitone position fold. Depends on fnb_pkg.
module fnb_pitch_pipe
    import fnb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  in_item_t    in_data,
    input  logic [4:0]  bend_range,
    output stage_ctl_t  s2_ctl,
    output stage_ctl_t  s3_ctl,
    output logic [10:0] s3_pos
);

    stage_ctl_t        s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic signed [8:0] s1_semi_reg;
    logic signed [8:0] s1_bend_reg;
    logic signed [13:0] s2_term_reg;
    logic [6:0]        s2_semi_reg;
    logic [10:0]       s3_pos_reg;

    stage_ctl_t        s1_ctl_next;
    logic signed [8:0] s1_semi_next;
    logic [13:0]       bend_diff;
    logic signed [14:0] term_full;
    logic [7:0]        semi_x;
    logic [6:0]        s2_semi_next;
    logic signed [16:0] pos_sum;
    logic signed [11:0] pos_raw;
    logic [9:0]        pos_x;
    logic [10:0]       s3_pos_next;

    always_comb
    begin
        s1_ctl_next.valid  = in_valid;
        s1_ctl_next.key_on = in_data.key_on;
        s1_ctl_next.voice  = in_data.voice_index;
        s1_semi_next = $signed({2'b00, in_data.note_number})
                       + $signed({in_data.transpose[7], in_data.transpose}) - SEMI_OFFSET;
        bend_diff = in_data.pitch_bend - BEND_CENTER;
    end

    always_comb
    begin
        term_full = s1_bend_reg * $signed({1'b0, bend_range});
        semi_x = 8'(s1_semi_reg);
        s2_semi_next = 7'(s1_semi_reg);
        if (s1_semi_reg < 0)
        begin
            semi_x = 8'(s1_semi_reg + SEMI_NEG_BIAS);
            s2_semi_next = {3'b000, mod12(semi_x)};
        end
        else if (s1_semi_reg > SEMI_MAX)
        begin
            semi_x = 8'(s1_semi_reg - SEMI_TOP_BASE);
            s2_semi_next = 7'(SEMI_TOP_BASE) + {3'b000, mod12(semi_x)};
        end
    end

    always_comb
    begin
        pos_sum = {{3{s2_term_reg[13]}}, s2_term_reg} + $signed({2'b00, s2_semi_reg, 8'b0})
                  + 17'sd8;
        pos_raw = pos_sum[15:4];
        pos_x = pos_raw[9:0];
        s3_pos_next = pos_raw[10:0];
        if (pos_raw < 0)
        begin
            pos_x = 10'(pos_raw + POS_NEG_BIAS);
            s3_pos_next = {3'b000, mod192(pos_x)};
        end
        else if (pos_raw > POS_MAX)
        begin
            pos_x = 10'(pos_raw - POS_TOP_BASE);
            s3_pos_next = 11'(POS_TOP_BASE) + {3'b000, mod192(pos_x)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else if (en)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_semi_reg <= s1_semi_next;
            s1_bend_reg <= $signed(bend_diff[13:5]);
            s2_term_reg <= term_full[13:0];
            s2_semi_reg <= s2_semi_next;
            s3_pos_reg  <= s3_pos_next;
        end
    end

    assign s2_ctl = s2_ctl_reg;
    assign s3_ctl = s3_ctl_reg;
    assign s3_pos = s3_pos_reg;

endmodule

[hw/rtl/fnb_block_calc.sv]
// Table lookup and block correction from a folded pitch position.
// Depends on fnb_pkg.
module fnb_block_calc
    import fnb_pkg::*;
(
    input  logic [10:0] pos,
    output logic [7:0]  fnum_low,
    output logic [7:0]  key_block
);

    logic [4:0]  oct_q;
    logic [3:0]  semi_r;
    logic [15:0] freq;
    logic [2:0]  blk;
    logic [1:0]  fhi;

    always_comb
    begin
        oct_q  = div12({1'b0, pos[10:4]});
        semi_r = mod12({1'b0, pos[10:4]});
        freq   = FNUM_TABLE[{semi_r, pos[3:0]}];
        if (oct_q == 5'd0 && !freq[15])
        begin
            blk      = 3'd0;
            fhi      = freq[10:9];
            fnum_low = freq[8:1];
        end
        else
        begin
            blk      = 3'(oct_q - 5'd1 + {4'b0, freq[15]});
            fhi      = freq[9:8];
            fnum_low = freq[7:0];
        end
        key_block = {3'b000, blk, fhi} | KEY_BIT;
    end

endmodule

[hw/rtl/midi_note_to_fm_fnum_block.sv]
// Top level of the note to F-number block: pitch pipeline, per-voice
// key/block shadow RAM and output register. Depends on fnb_pkg, fnb_ram,
// fnb_pitch_pipe and fnb_block_calc.
//
// Use: send one request word on in_valid/in_ready/in_data; one result word
// per request comes back on out_valid/out_ready/out_data in request order.
// cfg_valid/cfg_data writes the pitch bend range (cfg_ready is always high);
// write it only while no request is in flight.
// A request passes pitch stages s1, s2, s3 and the output register before
// out_valid rises. Throughput: one word per cycle while the receiver takes
// each word, set by the four-stage pipeline and the read-modify-write of
// the shadow RAM (same-voice accesses in adjacent stages are forwarded).
// Key-off reads the shadow byte of its voice and sends it with the key bit
// cleared; key-on writes its new key/block byte into the shadow.
// Reset: the bend range returns to 12, all shadow entries read as zero and
// the pipeline empties.
// Receiver stall: when out_ready is low with a word waiting, the whole
// pipeline holds and in_ready drops until the word is taken.
module midi_note_to_fm_fnum_block
    import fnb_pkg::*;
#(
    parameter int VOICE_COUNT = 9
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data
);

    localparam int AW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    logic                   en;
    logic [4:0]             bend_range_reg;
    stage_ctl_t             s2_ctl, s3_ctl;
    logic [10:0]            s3_pos;
    logic [7:0]             calc_fnum_low, calc_key_block;
    logic [7:0]             shadow_rdata;
    logic                   s2_in_range, s3_in_range;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [VOICE_COUNT-1:0] shadow_valid_reg;
    logic                   rd_hit_reg, fwd_hit_reg;
    logic [7:0]             fwd_kb_reg;
    logic [7:0]             stored_kb;
    logic                   out_valid_reg;
    out_item_t              out_data_reg, out_data_next;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    fnb_pitch_pipe u_pitch (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .bend_range (bend_range_reg),
        .s2_ctl     (s2_ctl),
        .s3_ctl     (s3_ctl),
        .s3_pos     (s3_pos)
    );

    fnb_block_calc u_calc (
        .pos       (s3_pos),
        .fnum_low  (calc_fnum_low),
        .key_block (calc_key_block)
    );

    assign s2_in_range = 32'(s2_ctl.voice) < VOICE_COUNT;
    assign s3_in_range = 32'(s3_ctl.voice) < VOICE_COUNT;
    assign wr_en       = en && s3_ctl.valid && s3_ctl.key_on && s3_in_range;
    assign wr_addr     = AW'(s3_ctl.voice);
    assign rd_addr     = AW'(s2_ctl.voice);

    fnb_ram #(
        .WIDTH (8),
        .DEPTH (VOICE_COUNT),
        .AW    (AW)
    ) u_shadow (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (calc_key_block),
        .re    (en),
        .raddr (rd_addr),
        .rdata (shadow_rdata)
    );

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            stored_kb = fwd_kb_reg;
        end
        else if (rd_hit_reg)
        begin
            stored_kb = shadow_rdata;
        end
        else
        begin
            stored_kb = 8'h00;
        end

        out_data_next.voice_out = s3_ctl.voice;
        if (s3_ctl.key_on)
        begin
            out_data_next.low_valid      = 1'b1;
            out_data_next.fnum_low       = calc_fnum_low;
            out_data_next.key_block_high = calc_key_block;
        end
        else
        begin
            out_data_next.low_valid      = 1'b0;
            out_data_next.fnum_low       = 8'h00;
            out_data_next.key_block_high = stored_kb & KEY_OFF_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bend_range_reg   <= BEND_RANGE_RESET;
            shadow_valid_reg <= '0;
            out_valid_reg    <= 1'b0;
            rd_hit_reg       <= 1'b0;
            fwd_hit_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                bend_range_reg <= cfg_data;
            end
            if (wr_en)
            begin
                shadow_valid_reg[wr_addr] <= 1'b1;
            end
            if (en)
            begin
                out_valid_reg <= s3_ctl.valid;
                rd_hit_reg    <= s2_in_range && shadow_valid_reg[rd_addr];
                fwd_hit_reg   <= wr_en && (s3_ctl.voice == s2_ctl.voice);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            fwd_kb_reg   <= calc_key_block;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_key_off_word : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.low_valid
        |-> out_data.fnum_low == 8'h00 && !out_data.key_block_high[5])
        else $error("key-off word carries F-number or key bit");

    a_key_on_word : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.low_valid
        |-> out_data.key_block_high[5] && out_data.key_block_high[7:6] == 2'b00)
        else $error("key-on word has bad key/block byte");

    a_shadow_mark : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> shadow_valid_reg[$past(wr_addr)])
        else $error("shadow entry not marked after write");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for midi_note_to_fm_fnum_block: directed and random pitch/key requests,
// checked against an in-bench F-number/block predictor with its own voice shadow.
// Depends on fnb_pkg (word types and constants) and the block's RTL.
module tb_top;
    import fnb_pkg::*;

    localparam int VOICE_COUNT = 9;

    localparam logic [15:0] FNUM_STEPS [192] = '{
        16'h02b2, 16'h02b4, 16'h02b7, 16'h02b9, 16'h02bc, 16'h02be, 16'h02c1, 16'h02c3,
        16'h02c6, 16'h02c9, 16'h02cb, 16'h02ce, 16'h02d0, 16'h02d3, 16'h02d6, 16'h02d8,
        16'h02db, 16'h02dd, 16'h02e0, 16'h02e3, 16'h02e5, 16'h02e8, 16'h02eb, 16'h02ed,
        16'h02f0, 16'h02f3, 16'h02f6, 16'h02f8, 16'h02fb, 16'h02fe, 16'h0301, 16'h0303,
        16'h0306, 16'h0309, 16'h030c, 16'h030f, 16'h0311, 16'h0314, 16'h0317, 16'h031a,
        16'h031d, 16'h0320, 16'h0323, 16'h0326, 16'h0329, 16'h032b, 16'h032e, 16'h0331,
        16'h0334, 16'h0337, 16'h033a, 16'h033d, 16'h0340, 16'h0343, 16'h0346, 16'h0349,
        16'h034c, 16'h034f, 16'h0352, 16'h0356, 16'h0359, 16'h035c, 16'h035f, 16'h0362,
        16'h0365, 16'h0368, 16'h036b, 16'h036f, 16'h0372, 16'h0375, 16'h0378, 16'h037b,
        16'h037f, 16'h0382, 16'h0385, 16'h0388, 16'h038c, 16'h038f, 16'h0392, 16'h0395,
        16'h0399, 16'h039c, 16'h039f, 16'h03a3, 16'h03a6, 16'h03a9, 16'h03ad, 16'h03b0,
        16'h03b4, 16'h03b7, 16'h03bb, 16'h03be, 16'h03c1, 16'h03c5, 16'h03c8, 16'h03cc,
        16'h03cf, 16'h03d3, 16'h03d7, 16'h03da, 16'h03de, 16'h03e1, 16'h03e5, 16'h03e8,
        16'h03ec, 16'h03f0, 16'h03f3, 16'h03f7, 16'h03fb, 16'h03fe, 16'hfe01, 16'hfe03,
        16'hfe05, 16'hfe07, 16'hfe08, 16'hfe0a, 16'hfe0c, 16'hfe0e, 16'hfe10, 16'hfe12,
        16'hfe14, 16'hfe16, 16'hfe18, 16'hfe1a, 16'hfe1c, 16'hfe1e, 16'hfe20, 16'hfe21,
        16'hfe23, 16'hfe25, 16'hfe27, 16'hfe29, 16'hfe2b, 16'hfe2d, 16'hfe2f, 16'hfe31,
        16'hfe34, 16'hfe36, 16'hfe38, 16'hfe3a, 16'hfe3c, 16'hfe3e, 16'hfe40, 16'hfe42,
        16'hfe44, 16'hfe46, 16'hfe48, 16'hfe4a, 16'hfe4c, 16'hfe4f, 16'hfe51, 16'hfe53,
        16'hfe55, 16'hfe57, 16'hfe59, 16'hfe5c, 16'hfe5e, 16'hfe60, 16'hfe62, 16'hfe64,
        16'hfe67, 16'hfe69, 16'hfe6b, 16'hfe6d, 16'hfe6f, 16'hfe72, 16'hfe74, 16'hfe76,
        16'hfe79, 16'hfe7b, 16'hfe7d, 16'hfe7f, 16'hfe82, 16'hfe84, 16'hfe86, 16'hfe89,
        16'hfe8b, 16'hfe8d, 16'hfe90, 16'hfe92, 16'hfe95, 16'hfe97, 16'hfe99, 16'hfe9c,
        16'hfe9e, 16'hfea1, 16'hfea3, 16'hfea5, 16'hfea8, 16'hfeaa, 16'hfead, 16'hfeaf
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data = '0;

    logic [7:0] key_block_mirror [VOICE_COUNT];
    logic [4:0] bend_range_mirror;
    out_item_t  fnum_expected_q [$];
    int         mismatches = 0;
    bit         tx_throttle = 1'b1;
    bit         rx_throttle = 1'b1;
    int         rx_hold = 0;

    midi_note_to_fm_fnum_block #(.VOICE_COUNT(VOICE_COUNT)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic out_item_t predict_fnum(in_item_t w);
        out_item_t   r;
        int          bend;
        int          term;
        int          semi;
        int          pos;
        int          note;
        int          blk;
        logic [15:0] wrap;
        logic [15:0] freq;
        logic [7:0]  kb;
        bit          in_range;
        in_range = w.voice_index < VOICE_COUNT;
        r.voice_out = w.voice_index;
        if (!w.key_on)
        begin
            kb = in_range ? key_block_mirror[w.voice_index] : 8'h00;
            r.low_valid = 1'b0;
            r.fnum_low = 8'h00;
            r.key_block_high = kb & KEY_OFF_MASK;
            return r;
        end
        bend = (int'(w.pitch_bend) - 8192) >>> 5;
        wrap = 16'(bend * int'(bend_range_mirror));
        term = int'($signed(wrap));
        semi = int'(w.note_number) + int'($signed(w.transpose)) - 12;
        while (semi < 0) semi += 12;
        while (semi > 95) semi -= 12;
        wrap = 16'(term + semi * 256 + 8);
        pos = int'($signed(wrap)) >>> 4;
        while (pos < 0) pos += 192;
        while (pos > 1535) pos -= 192;
        note = pos / 16;
        freq = FNUM_STEPS[(note % 12) * 16 + pos % 16];
        blk = note / 12 - 1;
        if (freq[15]) blk++;
        if (blk < 0)
        begin
            blk++;
            freq = (freq >> 1) | (freq & 16'h8000);
        end
        kb = 8'(int'(freq[9:8]) | (blk << 2)) | KEY_BIT;
        if (in_range) key_block_mirror[w.voice_index] = kb;
        r.low_valid = 1'b1;
        r.fnum_low = freq[7:0];
        r.key_block_high = kb;
        return r;
    endfunction

    function automatic in_item_t make_request(logic [3:0] voice, bit key, int note, int trans,
                                              int bend);
        in_item_t w;
        w.voice_index = voice;
        w.key_on = key;
        w.note_number = 7'(note);
        w.transpose = 8'(trans);
        w.pitch_bend = 14'(bend);
        return w;
    endfunction

    function automatic in_item_t random_request(bit key, logic [3:0] voice);
        in_item_t w;
        int       r;
        w.voice_index = voice;
        w.key_on = key;
        w.note_number = 7'($urandom_range(0, 127));
        r = $urandom_range(0, 9);
        if (r < 7) w.transpose = 8'(int'($urandom_range(0, 48)) - 24);
        else w.transpose = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r < 5) w.pitch_bend = 14'($urandom_range(8192 - 512, 8192 + 511));
        else if (r < 9) w.pitch_bend = 14'($urandom_range(0, 16383));
        else w.pitch_bend = $urandom_range(0, 1) ? 14'h3FFF : 14'h0000;
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!tx_throttle) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string why, out_item_t exp_word, out_item_t got_word);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch (%s): expected voice %0d low_valid %0b fnum_low %02h",
                     $realtime, why, exp_word.voice_out, exp_word.low_valid, exp_word.fnum_low,
                     " kbh %02h, got voice %0d low_valid %0b fnum_low %02h kbh %02h",
                     exp_word.key_block_high, got_word.voice_out, got_word.low_valid,
                     got_word.fnum_low, got_word.key_block_high);
    endtask

    always @(posedge clk)
    begin
        out_item_t exp_word;
        if (rst_n && out_valid && out_ready)
        begin
            if (fnum_expected_q.size() == 0)
                report_mismatch("no word expected", '0, out_data);
            else
            begin
                exp_word = fnum_expected_q.pop_front();
                if (out_data.voice_out !== exp_word.voice_out ||
                    out_data.low_valid !== exp_word.low_valid ||
                    out_data.fnum_low !== exp_word.fnum_low ||
                    out_data.key_block_high !== exp_word.key_block_high)
                    report_mismatch("field", exp_word, out_data);
            end
        end
    end

    initial
    begin
        int r;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
                rx_hold--;
            else if (!rx_throttle)
                out_ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    out_ready <= 1'b1;
                else if (r < 95)
                begin
                    out_ready <= 1'b0;
                    rx_hold = $urandom_range(0, 3);
                end
                else
                begin
                    out_ready <= 1'b0;
                    rx_hold = $urandom_range(10, 40);
                end
            end
        end
    end

    task automatic send_word(in_item_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        fnum_expected_q = {fnum_expected_q, predict_fnum(w)};
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (fnum_expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_bend_range(logic [4:0] value);
        wait_for_idle();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        bend_range_mirror = value;
    endtask

    task automatic test_shadow_after_reset();
        send_word(make_request(4'd0, 1'b0, 0, 0, 8192));
        send_word(make_request(4'd8, 1'b0, 127, -1, 16383));
        send_word(make_request(4'd15, 1'b0, 64, 5, 0));
    endtask

    task automatic test_field_extremes();
        send_word(make_request(4'd0, 1'b1, 0, -128, 0));
        send_word(make_request(4'd8, 1'b1, 127, 127, 16383));
        send_word(make_request(4'd8, 1'b0, 0, 0, 0));
        send_word(make_request(4'd15, 1'b1, 60, 0, 8192));
        send_word(make_request(4'd15, 1'b0, 60, 0, 8192));
        send_word(make_request(4'd1, 1'b1, 85, -43, 8191));
    endtask

    task automatic test_low_octave_block();
        send_word(make_request(4'd2, 1'b1, 12, 0, 8192));
        send_word(make_request(4'd3, 1'b1, 18, 0, 8768));
        send_word(make_request(4'd4, 1'b1, 19, 0, 8192));
        send_word(make_request(4'd5, 1'b1, 0, 0, 0));
        send_word(make_request(4'd4, 1'b0, 19, 0, 8192));
    endtask

    task automatic test_bend_range_extremes();
        write_bend_range(5'd0);
        send_word(make_request(4'd6, 1'b1, 60, 0, 16383));
        write_bend_range(5'd31);
        send_word(make_request(4'd7, 1'b1, 127, 127, 16383));
        send_word(make_request(4'd7, 1'b1, 0, -128, 0));
        write_bend_range(5'd24);
        send_word(make_request(4'd0, 1'b1, 12, 0, 0));
        write_bend_range(5'd1);
        send_word(make_request(4'd1, 1'b1, 70, 3, 16383));
    endtask

    task automatic test_random_traffic(int items_per_phase);
        logic [4:0] ranges [7];
        bit         held [VOICE_COUNT];
        in_item_t   w;
        logic [3:0] v;
        int         r;
        ranges = '{5'd12, 5'd1, 5'd24, 5'd0, 5'd31, 5'($urandom_range(1, 24)),
                   5'($urandom_range(0, 31))};
        foreach (held[i]) held[i] = 1'b0;
        foreach (ranges[p])
        begin
            write_bend_range(ranges[p]);
            for (int n = 0; n < items_per_phase; n++)
            begin
                if (n % 50 == 0)
                begin
                    tx_throttle = $urandom_range(0, 3) != 0;
                    rx_throttle = $urandom_range(0, 3) != 0;
                end
                r = $urandom_range(0, 99);
                if (r < 8)
                    w = random_request(1'($urandom_range(0, 1)), 4'($urandom_range(9, 15)));
                else if (r < 14)
                    w = random_request(1'b0, 4'($urandom_range(0, VOICE_COUNT - 1)));
                else
                begin
                    v = 4'($urandom_range(0, VOICE_COUNT - 1));
                    if (held[v] && $urandom_range(0, 1))
                    begin
                        w = random_request(1'b0, v);
                        held[v] = 1'b0;
                    end
                    else
                    begin
                        w = random_request(1'b1, v);
                        held[v] = 1'b1;
                    end
                end
                send_word(w);
            end
        end
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
    endtask

    initial
    begin
        foreach (key_block_mirror[i]) key_block_mirror[i] = 8'h00;
        bend_range_mirror = BEND_RANGE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_shadow_after_reset();
        test_field_extremes();
        test_low_octave_block();
        test_bend_range_extremes();
        test_random_traffic(190);
        wait_for_idle();
        if (mismatches == 0 && fnum_expected_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
